// ----- hw/rtl/csvtok_pkg.sv -----
// ---------------------------------------------------------------------------
// csvtok_pkg
// Shared types and constants of the csv row tokenizer: character codes,
// result kinds and the command word passed from the front to the back.
// ---------------------------------------------------------------------------
package csvtok_pkg;

   // default depth of the trailing whitespace buffer
   localparam int SPACE_DEPTH_DEFAULT = 16;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

   // character codes
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] SEP_RESET  = 8'h2C;

   // result kinds
   localparam logic [1:0] KIND_BYTE       = 2'd0;
   localparam logic [1:0] KIND_FIELD_END  = 2'd1;
   localparam logic [1:0] KIND_ROW_END    = 2'd2;
   localparam logic [1:0] KIND_STREAM_END = 2'd3;

   // back-end operations
   localparam logic [2:0] OP_NONE      = 3'd0;
   localparam logic [2:0] OP_SPACE     = 3'd1;
   localparam logic [2:0] OP_CONTENT   = 3'd2;
   localparam logic [2:0] OP_END_FIELD = 3'd3;
   localparam logic [2:0] OP_END_ROW   = 3'd4;
   localparam logic [2:0] OP_EOS       = 3'd5;

   // one command per accepted word that leaves work for the back
   typedef struct packed {
      logic       push_cr;    // buffer a lone cr before the operation
      logic       close_row;  // stream end: close the open row first
      logic [2:0] op;
      logic [7:0] data;
   } cmd_type;

   // space, tab, lf, vt, ff, cr
   function automatic logic is_ws(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

endpackage

// ----- hw/rtl/csv_row_tokenizer_top.sv -----
// ---------------------------------------------------------------------------
// csv_row_tokenizer_top
// Streaming csv tokenizer with quoting, whitespace trimming and LF / CRLF
// row ends; one text byte or a stream-end mark in, field words out.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata: in_byte; tuser: end_of_stream
//   rsp      out  rsp_tvalid/tready     tdata: field_byte, trim_overflow;
//                                       tuser: kind; tlast: last
//   csr      in   csr_we                csr_wdata: separator_char
//
// A content byte first flushes its buffered blanks, one per cycle while the
// result register is free; a lone CR is buffered as a blank first, and a
// stream end closing an open row emits a row end before the stream end.
// The front takes a word per cycle while the four-entry command queue has
// room; the back's single result register sets the output pace.
// Synchronous active-high reset; no clearing pass, the blank buffer is
// read only below its fill count.
// ---------------------------------------------------------------------------
module csv_row_tokenizer_top #(
   parameter int SPACE_DEPTH = csvtok_pkg::SPACE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] field_byte, [8] trim_overflow, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);

   csvtok_pkg::cmd_type q_in_data, q_out_data;
   logic                q_push, q_full, q_pop, q_empty;
   logic [7:0]          rsp_byte;
   logic                rsp_ovf;

   // classifying front
   csvtok_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_eos    (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_in_data)
   );

   // command queue
   csvtok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   // executing back
   csvtok_back #(
      .SPACE_DEPTH (SPACE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (!q_empty),
      .cmd        (q_out_data),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_byte   (rsp_byte),
      .rsp_ovf    (rsp_ovf),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_ovf, rsp_byte};

   // checks

   // queue drains on reset, so the input side is open right after it
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

   // no result word straight out of reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // only field bytes carry a byte value
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != csvtok_pkg::KIND_BYTE)) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("non-byte word with a byte value");

   // overflow flag only on field ends
   a_ovf_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[8]) |->
      ((rsp_tuser == csvtok_pkg::KIND_FIELD_END) || (rsp_tuser == csvtok_pkg::KIND_ROW_END)))
      else $error("trim overflow outside a field end");

   // stream end always finishes its word's results
   a_eos_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == csvtok_pkg::KIND_STREAM_END)) |-> rsp_tlast)
      else $error("stream end without last");

endmodule

// ----- hw/rtl/csvtok_queue.sv -----
// ---------------------------------------------------------------------------
// csvtok_queue
// Short command queue that decouples the classifying front from the back.
// ---------------------------------------------------------------------------
module csvtok_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csvtok_pkg::cmd_type push_data,
   output logic                full,
   input  logic                pop,
   output csvtok_pkg::cmd_type pop_data,
   output logic                empty
);

   csvtok_pkg::cmd_type                  entry_ff [csvtok_pkg::QUEUE_DEPTH];
   logic [csvtok_pkg::QUEUE_PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [csvtok_pkg::QUEUE_PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [csvtok_pkg::QUEUE_PW:0]        fill_ff, fill_in;

   assign full     = (fill_ff == (csvtok_pkg::QUEUE_PW+1)'(csvtok_pkg::QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + (csvtok_pkg::QUEUE_PW)'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + (csvtok_pkg::QUEUE_PW)'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (csvtok_pkg::QUEUE_PW+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (csvtok_pkg::QUEUE_PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/csvtok_front.sv -----
// ---------------------------------------------------------------------------
// csvtok_front
// Accepts input words, tracks quoting and row state, and turns each word
// that leaves work for the back into one command for the back.
// ---------------------------------------------------------------------------
module csvtok_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [7:0]          csr_wdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_byte,
   input  logic                req_eos,
   input  logic                q_full,
   output logic                q_push,
   output csvtok_pkg::cmd_type q_data
);

   logic [7:0] sep_ff;
   logic       in_quoted_ff, in_quoted_in;
   logic       has_content_ff, has_content_in;
   logic       quote_pend_ff, quote_pend_in;
   logic       cr_pend_ff, cr_pend_in;
   logic       field_start_ff, field_start_in;
   logic       row_open_ff, row_open_in;
   logic       do_handle;
   logic       accept;
   csvtok_pkg::cmd_type cmd;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // classification and next parse state
   always_comb begin
      in_quoted_in   = in_quoted_ff;
      has_content_in = has_content_ff;
      quote_pend_in  = quote_pend_ff;
      cr_pend_in     = cr_pend_ff;
      field_start_in = field_start_ff;
      row_open_in    = row_open_ff;
      cmd            = '0;
      cmd.op         = csvtok_pkg::OP_NONE;
      cmd.data       = req_byte;
      do_handle      = 1'b0;

      if (req_eos) begin
         // stream end: flush lone cr, close open row, back to start
         cmd.push_cr    = cr_pend_ff;
         cmd.close_row  = row_open_ff;
         cmd.op         = csvtok_pkg::OP_EOS;
         in_quoted_in   = 1'b0;
         has_content_in = 1'b0;
         quote_pend_in  = 1'b0;
         cr_pend_in     = 1'b0;
         field_start_in = 1'b1;
         row_open_in    = 1'b0;
      end else if (cr_pend_ff) begin
         cr_pend_in = 1'b0;
         if (req_byte == csvtok_pkg::CH_LF) begin
            cmd.op         = csvtok_pkg::OP_END_ROW;
            has_content_in = 1'b0;
            field_start_in = 1'b1;
            in_quoted_in   = 1'b0;
            quote_pend_in  = 1'b0;
            row_open_in    = 1'b0;
         end else begin
            cmd.push_cr = 1'b1;
            do_handle   = 1'b1;
         end
      end else if (quote_pend_ff) begin
         quote_pend_in = 1'b0;
         if (req_byte == csvtok_pkg::CH_QUOTE) begin
            cmd.op         = csvtok_pkg::OP_CONTENT;
            has_content_in = 1'b1;
         end else begin
            in_quoted_in = 1'b0;
            do_handle    = 1'b1;
         end
      end else begin
         do_handle = 1'b1;
      end

      // ordinary byte handling
      if (do_handle) begin
         row_open_in = 1'b1;
         if (in_quoted_in) begin
            field_start_in = 1'b0;
            if (req_byte == csvtok_pkg::CH_QUOTE) begin
               quote_pend_in = 1'b1;
            end else if (csvtok_pkg::is_ws(req_byte)) begin
               if (has_content_in) begin
                  cmd.op = csvtok_pkg::OP_SPACE;
               end
            end else begin
               cmd.op         = csvtok_pkg::OP_CONTENT;
               has_content_in = 1'b1;
            end
         end else if (field_start_in && (req_byte == csvtok_pkg::CH_QUOTE)) begin
            in_quoted_in   = 1'b1;
            field_start_in = 1'b0;
         end else begin
            field_start_in = 1'b0;
            if (req_byte == sep_ff) begin
               cmd.op         = csvtok_pkg::OP_END_FIELD;
               has_content_in = 1'b0;
               field_start_in = 1'b1;
               in_quoted_in   = 1'b0;
               quote_pend_in  = 1'b0;
            end else if (req_byte == csvtok_pkg::CH_CR) begin
               cr_pend_in = 1'b1;
            end else if (req_byte == csvtok_pkg::CH_LF) begin
               cmd.op         = csvtok_pkg::OP_END_ROW;
               has_content_in = 1'b0;
               field_start_in = 1'b1;
               in_quoted_in   = 1'b0;
               quote_pend_in  = 1'b0;
               row_open_in    = 1'b0;
               cr_pend_in     = 1'b0;
            end else if (csvtok_pkg::is_ws(req_byte)) begin
               if (has_content_in) begin
                  cmd.op = csvtok_pkg::OP_SPACE;
               end
            end else begin
               cmd.op         = csvtok_pkg::OP_CONTENT;
               has_content_in = 1'b1;
            end
         end
      end
   end

   // words that leave nothing for the back are not queued
   assign q_push = accept && !((cmd.op == csvtok_pkg::OP_NONE) && !cmd.push_cr);
   assign q_data = cmd;

   // separator register
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= csvtok_pkg::SEP_RESET;
      end else if (csr_we) begin
         sep_ff <= csr_wdata;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_quoted_ff   <= 1'b0;
         has_content_ff <= 1'b0;
         quote_pend_ff  <= 1'b0;
         cr_pend_ff     <= 1'b0;
         field_start_ff <= 1'b1;
         row_open_ff    <= 1'b0;
      end else if (accept) begin
         in_quoted_ff   <= in_quoted_in;
         has_content_ff <= has_content_in;
         quote_pend_ff  <= quote_pend_in;
         cr_pend_ff     <= cr_pend_in;
         field_start_ff <= field_start_in;
         row_open_ff    <= row_open_in;
      end
   end

endmodule

// ----- hw/rtl/csvtok_back.sv -----
// ---------------------------------------------------------------------------
// csvtok_back
// Carries out queued commands: buffers trailing whitespace, flushes it in
// front of content, and drives the result register.
// ---------------------------------------------------------------------------
module csvtok_back #(
   parameter int SPACE_DEPTH = csvtok_pkg::SPACE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  csvtok_pkg::cmd_type cmd,
   output logic                cmd_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_byte,
   output logic                rsp_ovf,
   output logic                rsp_last
);

   localparam int CW    = $clog2(SPACE_DEPTH + 1);
   localparam int AW    = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
   localparam int MEM_N = 1 << AW;

   logic [7:0]    space_buf_ff [MEM_N];
   logic [7:0]    rd_data_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          ovf_ff, ovf_in;
   logic          cr_done_ff, cr_done_in;
   logic          close_done_ff, close_done_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_kind_ff;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_ovf_ff;
   logic          rsp_last_ff;
   logic          out_free;
   logic          emit;
   logic [1:0]    e_kind;
   logic [7:0]    e_byte;
   logic          e_ovf;
   logic          e_last;
   logic          do_space;
   logic [7:0]    space_byte;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign wr_addr  = count_ff[AW-1:0];

   // command execution
   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      ovf_in        = ovf_ff;
      cr_done_in    = cr_done_ff;
      close_done_in = close_done_ff;
      cmd_pop       = 1'b0;
      emit          = 1'b0;
      e_kind        = csvtok_pkg::KIND_BYTE;
      e_byte        = '0;
      e_ovf         = 1'b0;
      e_last        = 1'b0;
      do_space      = 1'b0;
      space_byte    = cmd.data;
      wr_en         = 1'b0;

      if (cmd_valid) begin
         if (cmd.push_cr && !cr_done_ff) begin
            // lone cr goes to the whitespace buffer first
            do_space   = 1'b1;
            space_byte = csvtok_pkg::CH_CR;
            cr_done_in = 1'b1;
         end else begin
            unique case (cmd.op)
               csvtok_pkg::OP_SPACE: begin
                  do_space = 1'b1;
                  cmd_pop  = 1'b1;
               end
               csvtok_pkg::OP_CONTENT: begin
                  if (out_free) begin
                     emit = 1'b1;
                     if (ptr_ff < count_ff) begin
                        e_byte = rd_data_ff;
                        ptr_in = ptr_ff + CW'(1);
                     end else begin
                        e_byte   = cmd.data;
                        e_last   = 1'b1;
                        ptr_in   = '0;
                        count_in = '0;
                        cmd_pop  = 1'b1;
                     end
                  end
               end
               csvtok_pkg::OP_END_FIELD, csvtok_pkg::OP_END_ROW: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     e_kind   = (cmd.op == csvtok_pkg::OP_END_ROW) ?
                                csvtok_pkg::KIND_ROW_END : csvtok_pkg::KIND_FIELD_END;
                     e_ovf    = ovf_ff;
                     e_last   = 1'b1;
                     count_in = '0;
                     ovf_in   = 1'b0;
                     cmd_pop  = 1'b1;
                  end
               end
               csvtok_pkg::OP_EOS: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     count_in = '0;
                     ovf_in   = 1'b0;
                     if (cmd.close_row && !close_done_ff) begin
                        e_kind        = csvtok_pkg::KIND_ROW_END;
                        e_ovf         = ovf_ff;
                        close_done_in = 1'b1;
                     end else begin
                        e_kind  = csvtok_pkg::KIND_STREAM_END;
                        e_last  = 1'b1;
                        cmd_pop = 1'b1;
                     end
                  end
               end
               default: begin
                  cmd_pop = 1'b1;
               end
            endcase
         end
      end

      // whitespace push, or overflow once the buffer is full
      if (do_space) begin
         if (count_ff < CW'(SPACE_DEPTH)) begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd_pop) begin
         cr_done_in    = 1'b0;
         close_done_in = 1'b0;
      end
   end

   assign rd_addr      = ptr_in[AW-1:0];
   assign rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // whitespace buffer, read data registered with write forwarding
   always_ff @(posedge clock) begin
      if (wr_en) begin
         space_buf_ff[wr_addr] <= space_byte;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= space_byte;
      end else begin
         rd_data_ff <= space_buf_ff[rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ptr_ff        <= '0;
         ovf_ff        <= 1'b0;
         cr_done_ff    <= 1'b0;
         close_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         ovf_ff        <= ovf_in;
         cr_done_ff    <= cr_done_in;
         close_done_ff <= close_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= e_kind;
         rsp_byte_ff <= e_byte;
         rsp_ovf_ff  <= e_ovf;
         rsp_last_ff <= e_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_ovf    = rsp_ovf_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
